// ----- hw/rtl/mfa_pkg.sv -----
// mfa_pkg: shared widths, limits, codes and record types for the mixed fraction adder
// depends on nothing; every other file of the block imports it
package mfa_pkg;

  localparam int FIELD_W     = 20;
  localparam int STAT_W      = 2;
  localparam int VALUE_LIMIT = 1000000;
  localparam int PROD_W      = 2 * FIELD_W;          // whole * den, den * den
  localparam int SCALE_W     = PROD_W + 1;           // whole * den + num
  localparam int TERM_W      = SCALE_W + FIELD_W;    // scaled numerator term
  localparam int MAG_W       = TERM_W + 1;           // sum of two terms
  localparam int SHIFT_W     = $clog2(FIELD_W);
  localparam int CNT_W       = $clog2(FIELD_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_DEN  = 2'd1,
    STATUS_TOO_LARGE = 2'd2
  } status_t;

  // job handed from the front to the back
  typedef struct packed {
    status_t              status;
    logic                 neg;
    logic [FIELD_W-1:0]   mag;
    logic [FIELD_W-1:0]   den;
  } mfa_job_t;

  typedef struct packed {
    logic                 neg;
    logic [FIELD_W-1:0]   whole;
    logic [FIELD_W-1:0]   num;
    logic [FIELD_W-1:0]   den;
    status_t              status;
  } mfa_result_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_PROD,
    FR_SCALE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIV_MAG,
    BK_DIV_DEN,
    BK_DIV_WHOLE,
    BK_DONE
  } back_state_t;

endpackage

// ----- hw/rtl/mfa_in_if.sv -----
// mfa_in_if: operand channel of the mixed fraction adder, valid/ready plus two mixed fractions
// depends on mfa_pkg
interface mfa_in_if;
  import mfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               a_negative;
  logic [FIELD_W-1:0] a_whole;
  logic [FIELD_W-1:0] a_num;
  logic [FIELD_W-1:0] a_den;
  logic               b_negative;
  logic [FIELD_W-1:0] b_whole;
  logic [FIELD_W-1:0] b_num;
  logic [FIELD_W-1:0] b_den;

  modport source (
    output valid, a_negative, a_whole, a_num, a_den,
           b_negative, b_whole, b_num, b_den,
    input  ready
  );
  modport sink (
    input  valid, a_negative, a_whole, a_num, a_den,
           b_negative, b_whole, b_num, b_den,
    output ready
  );
endinterface

// ----- hw/rtl/mfa_out_if.sv -----
// mfa_out_if: result channel of the mixed fraction adder, valid/ready plus reduced sum
// depends on mfa_pkg
interface mfa_out_if;
  import mfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               sum_negative;
  logic [FIELD_W-1:0] sum_whole;
  logic [FIELD_W-1:0] sum_num;
  logic [FIELD_W-1:0] sum_den;
  logic [STAT_W-1:0]  status;

  modport source (
    output valid, sum_negative, sum_whole, sum_num, sum_den, status,
    input  ready
  );
  modport sink (
    input  valid, sum_negative, sum_whole, sum_num, sum_den, status,
    output ready
  );
endinterface

// ----- hw/rtl/mfa_front.sv -----
// mfa_front: accepts an operand word, forms the unreduced sum and classifies it
// depends on mfa_pkg and mfa_in_if
module mfa_front (
  input  logic              clk,
  input  logic              rst_n,
  mfa_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output mfa_pkg::mfa_job_t push_data
);
  import mfa_pkg::*;

  front_state_t state_r, state_nxt;

  logic               a_neg_r, b_neg_r;
  logic [FIELD_W-1:0] a_whole_r, a_num_r, a_den_r;
  logic [FIELD_W-1:0] b_whole_r, b_num_r, b_den_r;
  logic [PROD_W-1:0]  ta_r, tb_r, den_r;
  logic [TERM_W-1:0]  p_r, q_r;

  logic               accept;
  logic               p_ge_q;
  logic [MAG_W-1:0]   mag;
  logic               neg;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE:  if (accept) state_nxt = FR_PROD;
      FR_PROD:  state_nxt = FR_SCALE;
      FR_SCALE: state_nxt = FR_PUSH;
      FR_PUSH:  if (push_ready) state_nxt = FR_IDLE;
      default:  state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    case (state_r)
      FR_IDLE: in_ch.ready = 1'b1;
      FR_PUSH: push_valid  = 1'b1;
      default: begin
        in_ch.ready = 1'b0;
        push_valid  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operand capture and the two multiply stages
  always_ff @(posedge clk) begin
    if (accept) begin
      a_neg_r   <= in_ch.a_negative;
      a_whole_r <= in_ch.a_whole;
      a_num_r   <= in_ch.a_num;
      a_den_r   <= in_ch.a_den;
      b_neg_r   <= in_ch.b_negative;
      b_whole_r <= in_ch.b_whole;
      b_num_r   <= in_ch.b_num;
      b_den_r   <= in_ch.b_den;
    end
    if (state_r == FR_PROD) begin
      ta_r  <= PROD_W'(a_whole_r) * PROD_W'(a_den_r);
      tb_r  <= PROD_W'(b_whole_r) * PROD_W'(b_den_r);
      den_r <= PROD_W'(a_den_r) * PROD_W'(b_den_r);
    end
    if (state_r == FR_SCALE) begin
      p_r <= TERM_W'(SCALE_W'(ta_r) + SCALE_W'(a_num_r)) * TERM_W'(b_den_r);
      q_r <= TERM_W'(SCALE_W'(tb_r) + SCALE_W'(b_num_r)) * TERM_W'(a_den_r);
    end
  end

  // signed add of the two scaled terms in sign-magnitude form
  always_comb begin
    p_ge_q = p_r >= q_r;
    if (a_neg_r == b_neg_r) begin
      mag = MAG_W'(p_r) + MAG_W'(q_r);
      neg = a_neg_r;
    end else if (p_ge_q) begin
      mag = MAG_W'(p_r - q_r);
      neg = a_neg_r;
    end else begin
      mag = MAG_W'(q_r - p_r);
      neg = b_neg_r;
    end
    if (mag == '0) neg = 1'b0;

    push_data.neg = neg;
    push_data.mag = mag[FIELD_W-1:0];
    push_data.den = den_r[FIELD_W-1:0];
    if (a_den_r == '0 || b_den_r == '0) begin
      push_data.status = STATUS_ZERO_DEN;
    end else if (den_r >= PROD_W'(VALUE_LIMIT) || mag >= MAG_W'(VALUE_LIMIT)) begin
      push_data.status = STATUS_TOO_LARGE;
    end else begin
      push_data.status = STATUS_OK;
    end
  end

endmodule

// ----- hw/rtl/mfa_queue.sv -----
// mfa_queue: short register queue of jobs between front and back
// depends on mfa_pkg
module mfa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  mfa_pkg::mfa_job_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mfa_pkg::mfa_job_t pop_data
);
  import mfa_pkg::*;

  mfa_job_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push, do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- hw/rtl/mfa_back.sv -----
// mfa_back: binary gcd, three bit-serial divisions and the result register
// depends on mfa_pkg
module mfa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  mfa_pkg::mfa_job_t    pop_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mfa_pkg::mfa_result_t res_data
);
  import mfa_pkg::*;

  back_state_t state_r, state_nxt;

  status_t             status_r;
  logic                neg_r;
  logic [FIELD_W-1:0]  mag_r, den_r;
  logic [FIELD_W-1:0]  x_r, y_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic [FIELD_W-1:0]  n_r, d_r, whole_r, num_r;
  logic [FIELD_W-1:0]  dvd_r, rem_r, dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                res_valid_r;
  mfa_result_t         res_r;

  logic                take_job;
  logic                gcd_done;
  logic                div_last;
  logic                out_load;
  logic [FIELD_W:0]    trial;
  logic                trial_ge;
  logic [FIELD_W-1:0]  dvd_nxt, rem_nxt;

  assign take_job = pop_valid && pop_ready;
  assign gcd_done = x_r == '0 || y_r == '0;
  assign div_last = cnt_r == CNT_W'(FIELD_W - 1);

  // one restoring division step per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[FIELD_W-1]};
    trial_ge = trial >= {1'b0, dvs_r};
    rem_nxt  = trial_ge ? FIELD_W'(trial - {1'b0, dvs_r}) : trial[FIELD_W-1:0];
    dvd_nxt  = {dvd_r[FIELD_W-2:0], trial_ge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take_job) state_nxt = (pop_data.status == STATUS_OK) ? BK_GCD : BK_DONE;
      end
      BK_GCD:       if (gcd_done) state_nxt = BK_DIV_MAG;
      BK_DIV_MAG:   if (div_last) state_nxt = BK_DIV_DEN;
      BK_DIV_DEN:   if (div_last) state_nxt = BK_DIV_WHOLE;
      BK_DIV_WHOLE: if (div_last) state_nxt = BK_DONE;
      BK_DONE:      if (out_load) state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: pop_ready = 1'b1;
      BK_DONE: out_load  = !res_valid_r || res_ready;
      default: begin
        pop_ready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (take_job) begin
          status_r <= pop_data.status;
          neg_r    <= pop_data.neg;
          mag_r    <= pop_data.mag;
          den_r    <= pop_data.den;
          x_r      <= pop_data.mag;
          y_r      <= pop_data.den;
          shift_r  <= '0;
        end
      end
      BK_GCD: begin
        if (gcd_done) begin
          dvs_r <= FIELD_W'((x_r | y_r) << shift_r);
          dvd_r <= mag_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r     <= x_r >> 1;
          y_r     <= y_r >> 1;
          shift_r <= shift_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      BK_DIV_MAG: begin
        cnt_r <= cnt_r + 1'b1;
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        if (div_last) begin
          n_r   <= dvd_nxt;
          dvd_r <= den_r;
          rem_r <= '0;
          cnt_r <= '0;
        end
      end
      BK_DIV_DEN: begin
        cnt_r <= cnt_r + 1'b1;
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        if (div_last) begin
          d_r   <= dvd_nxt;
          dvs_r <= dvd_nxt;
          dvd_r <= n_r;
          rem_r <= '0;
          cnt_r <= '0;
        end
      end
      BK_DIV_WHOLE: begin
        cnt_r <= cnt_r + 1'b1;
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        if (div_last) begin
          whole_r <= dvd_nxt;
          num_r   <= rem_nxt;
        end
      end
      BK_DONE: begin
        if (out_load) begin
          res_r.status <= status_r;
          if (status_r == STATUS_OK) begin
            res_r.neg   <= neg_r;
            res_r.whole <= whole_r;
            res_r.num   <= num_r;
            res_r.den   <= d_r;
          end else begin
            res_r.neg   <= 1'b0;
            res_r.whole <= '0;
            res_r.num   <= '0;
            res_r.den   <= FIELD_W'(1);
          end
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule

// ----- hw/rtl/mixed_fraction_adder.sv -----
// mixed_fraction_adder: one word in, one reduced signed mixed fraction out
// a word that ends in an error status skips the back-end gcd and divisions; a valid sum runs
//   the binary gcd loop (one step a cycle) and three 20-step restoring divisions in turn
// the back takes one word per run; the front takes the next word once it has pushed the last
// reset: synchronous active-low rst_n empties the queue, idles both sequencers, drops out valid
// depends on mfa_pkg, mfa_in_if, mfa_out_if, mfa_front, mfa_queue, mfa_back
module mixed_fraction_adder (
  input  logic    clk,
  input  logic    rst_n,
  mfa_in_if.sink  in_ch,
  mfa_out_if.source out_ch
);
  import mfa_pkg::*;

  // front to queue
  logic        push_valid, push_ready;
  mfa_job_t    push_data;
  // queue to back
  logic        pop_valid, pop_ready;
  mfa_job_t    pop_data;
  // back result register
  logic        res_valid;
  mfa_result_t res_data;

  // front: captures the word, forms p, q and the product of the denominators
  // over two multiply stages, then classifies zero denominator and overflow
  mfa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // two-entry queue so the front can keep working while the back iterates
  mfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: gcd, reduce numerator and denominator, split the whole part,
  // and hold the finished word in its output register
  mfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res_data  (res_data)
  );

  // result channel straight from the output register
  assign out_ch.valid        = res_valid;
  assign out_ch.sum_negative = res_data.neg;
  assign out_ch.sum_whole    = res_data.whole;
  assign out_ch.sum_num      = res_data.num;
  assign out_ch.sum_den      = res_data.den;
  assign out_ch.status       = res_data.status;

endmodule

// ----- hw/rtl/mfa_checker.sv -----
// mfa_checker: port-level checks on the result channel of the mixed fraction adder
// depends on mfa_pkg; bound to mixed_fraction_adder at the end of this file
module mfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        sum_negative,
  input logic [mfa_pkg::FIELD_W-1:0] sum_whole,
  input logic [mfa_pkg::FIELD_W-1:0] sum_num,
  input logic [mfa_pkg::FIELD_W-1:0] sum_den,
  input logic [mfa_pkg::STAT_W-1:0]  status
);
  import mfa_pkg::*;

  // a stalled word stays valid, with its denominator and numerator unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sum_den) && $stable(sum_num))
    else $error("result word dropped or changed while stalled");

  // a good sum is a proper fraction
  a_ok_proper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STATUS_OK |-> sum_den != '0 && sum_num < sum_den)
    else $error("numerator not below denominator");

  // error words carry the fixed result fields
  a_err_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STATUS_OK |->
      !sum_negative && sum_whole == '0 && sum_num == '0 && sum_den == FIELD_W'(1))
    else $error("error word with nonzero result fields");

  // zero is positive
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sum_whole == '0 && sum_num == '0 |-> !sum_negative)
    else $error("negative zero sum");

endmodule

bind mixed_fraction_adder mfa_checker u_mfa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sum_negative (out_ch.sum_negative),
  .sum_whole    (out_ch.sum_whole),
  .sum_num      (out_ch.sum_num),
  .sum_den      (out_ch.sum_den),
  .status       (out_ch.status)
);

// ----- tb/sv/mixed_fraction_adder_tb.sv -----
// mixed_fraction_adder_tb: self-checking bench for the mixed fraction adder, a directed table
// then random operand words, every result checked against a typed-in or predicted reduced sum
// depends on mfa_pkg, mfa_in_if, mfa_out_if and the mixed_fraction_adder rtl
`timescale 1ns / 100ps

module mixed_fraction_adder_tb;
  import mfa_pkg::*;

  // one signed mixed fraction as it sits on the operand channel
  typedef struct packed {
    logic               neg;
    logic [FIELD_W-1:0] whole;
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
  } mixed_t;

  typedef struct packed {
    mixed_t a;
    mixed_t b;
  } operand_pair_t;

  // where a table row gets its expected sum
  typedef enum bit {
    FROM_PREDICTOR,
    TYPED_IN
  } sum_source_t;

  typedef struct packed {
    operand_pair_t ops;
    sum_source_t   src;
    mfa_result_t   sum;
  } directed_row_t;

  localparam int          RANDOM_WORDS = 880;
  localparam int          DRAIN_CYCLES = 200;   // well past the longest back-end run
  localparam int          TIMEOUT_NS   = 3_000_000;
  localparam int unsigned SAFE_MAG     = 499999; // keeps each term of a random sum in range

  // fixed results: zero sum, both error codes, and a filler for predicted rows
  localparam mfa_result_t ZERO_SUM      = '{1'b0, 20'd0, 20'd0, 20'd1, STATUS_OK};
  localparam mfa_result_t ZERO_DEN_SUM  = '{1'b0, 20'd0, 20'd0, 20'd1, STATUS_ZERO_DEN};
  localparam mfa_result_t TOO_LARGE_SUM = '{1'b0, 20'd0, 20'd0, 20'd1, STATUS_TOO_LARGE};
  localparam mfa_result_t UNTYPED       = ZERO_SUM;

  // directed table: extremes, both error codes, the limit boundary, zero sums of both
  // signs, every sign combination, improper and reducible fractions
  localparam int NUM_DIRECTED = 25;
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // all zero, smallest legal denominators
    '{'{'{1'b0, 20'd0, 20'd0, 20'd1}, '{1'b0, 20'd0, 20'd0, 20'd1}},
      TYPED_IN, ZERO_SUM},
    // zero denominator on a, on b with all other bits set, on both
    '{'{'{1'b0, 20'd5, 20'd1, 20'd0}, '{1'b0, 20'd2, 20'd1, 20'd3}},
      TYPED_IN, ZERO_DEN_SUM},
    '{'{'{1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, '{1'b1, 20'hFFFFF, 20'hFFFFF, 20'd0}},
      TYPED_IN, ZERO_DEN_SUM},
    '{'{'{1'b0, 20'd7, 20'd3, 20'd0}, '{1'b1, 20'd1, 20'd0, 20'd0}},
      TYPED_IN, ZERO_DEN_SUM},
    // largest in-range operands, then all ones that cancel but keep a huge denominator
    '{'{'{1'b0, 20'd999999, 20'd999999, 20'd999999}, '{1'b0, 20'd999999, 20'd999999,
      20'd999999}}, TYPED_IN, TOO_LARGE_SUM},
    '{'{'{1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, '{1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF}},
      TYPED_IN, TOO_LARGE_SUM},
    // denominator product exactly at the limit, then one below
    '{'{'{1'b0, 20'd0, 20'd0, 20'd1000}, '{1'b0, 20'd0, 20'd0, 20'd1000}},
      TYPED_IN, TOO_LARGE_SUM},
    '{'{'{1'b0, 20'd0, 20'd1, 20'd999}, '{1'b1, 20'd0, 20'd1, 20'd1001}},
      FROM_PREDICTOR, UNTYPED},
    // magnitude exactly at the limit, then one below of either sign
    '{'{'{1'b0, 20'd999999, 20'd1, 20'd1}, '{1'b0, 20'd0, 20'd0, 20'd1}},
      TYPED_IN, TOO_LARGE_SUM},
    '{'{'{1'b0, 20'd999999, 20'd0, 20'd1}, '{1'b0, 20'd0, 20'd0, 20'd1}},
      TYPED_IN, '{1'b0, 20'd999999, 20'd0, 20'd1, STATUS_OK}},
    '{'{'{1'b1, 20'd999999, 20'd0, 20'd1}, '{1'b1, 20'd0, 20'd0, 20'd1}},
      TYPED_IN, '{1'b1, 20'd999999, 20'd0, 20'd1, STATUS_OK}},
    // zero sums always come out positive
    '{'{'{1'b0, 20'd3, 20'd1, 20'd2}, '{1'b1, 20'd3, 20'd1, 20'd2}},
      TYPED_IN, ZERO_SUM},
    '{'{'{1'b1, 20'd0, 20'd0, 20'd5}, '{1'b0, 20'd0, 20'd0, 20'd7}},
      TYPED_IN, ZERO_SUM},
    '{'{'{1'b1, 20'd0, 20'd0, 20'd5}, '{1'b1, 20'd0, 20'd0, 20'd7}},
      TYPED_IN, ZERO_SUM},
    // the four sign combinations
    '{'{'{1'b0, 20'd0, 20'd1, 20'd2}, '{1'b0, 20'd0, 20'd1, 20'd3}},
      FROM_PREDICTOR, UNTYPED},
    '{'{'{1'b1, 20'd0, 20'd1, 20'd2}, '{1'b0, 20'd0, 20'd1, 20'd3}},
      FROM_PREDICTOR, UNTYPED},
    '{'{'{1'b0, 20'd0, 20'd1, 20'd2}, '{1'b1, 20'd0, 20'd1, 20'd3}},
      FROM_PREDICTOR, UNTYPED},
    '{'{'{1'b1, 20'd1, 20'd1, 20'd2}, '{1'b1, 20'd2, 20'd1, 20'd3}},
      FROM_PREDICTOR, UNTYPED},
    // improper numerator, and a sum that reduces to a whole number
    '{'{'{1'b0, 20'd0, 20'd7, 20'd2}, '{1'b0, 20'd0, 20'd0, 20'd1}},
      FROM_PREDICTOR, UNTYPED},
    '{'{'{1'b0, 20'd0, 20'd2, 20'd4}, '{1'b0, 20'd0, 20'd2, 20'd4}},
      FROM_PREDICTOR, UNTYPED},
    // out-of-range wholes that cancel exactly
    '{'{'{1'b0, 20'hFFFFF, 20'd0, 20'd1}, '{1'b1, 20'hFFFFF, 20'd0, 20'd1}},
      FROM_PREDICTOR, UNTYPED},
    // largest legal denominator, alone and in a near cancellation
    '{'{'{1'b0, 20'd0, 20'd1, 20'd999999}, '{1'b0, 20'd0, 20'd0, 20'd1}},
      FROM_PREDICTOR, UNTYPED},
    '{'{'{1'b0, 20'd0, 20'd999998, 20'd999999}, '{1'b1, 20'd0, 20'd1, 20'd1}},
      FROM_PREDICTOR, UNTYPED},
    // two wholes that just stay under the limit, then a mixed sum of opposite signs
    '{'{'{1'b0, 20'd499999, 20'd0, 20'd1}, '{1'b0, 20'd500000, 20'd0, 20'd1}},
      FROM_PREDICTOR, UNTYPED},
    '{'{'{1'b1, 20'd12, 20'd5, 20'd6}, '{1'b0, 20'd40, 20'd3, 20'd8}},
      FROM_PREDICTOR, UNTYPED}
  };

  logic clk;
  logic rst_n;

  mfa_in_if  in_ch ();
  mfa_out_if out_ch ();

  mixed_fraction_adder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // sums still owed by the block, oldest first
  mfa_result_t expected_sums [$];
  int          mismatches = 0;
  // while set, neither side idles
  bit          steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // exact signed sum of two mixed fractions, reduced by the euclidean gcd
  function automatic mfa_result_t sum_fractions(input operand_pair_t op);
    logic [63:0] p, q, mag, den, x, y, r, n, d;
    logic        neg;
    mfa_result_t res;
    res = ZERO_DEN_SUM;
    if (op.a.den == '0 || op.b.den == '0) return res;
    // each scaled term stays below 2^61
    p = (64'(op.a.whole) * 64'(op.a.den) + 64'(op.a.num)) * 64'(op.b.den);
    q = (64'(op.b.whole) * 64'(op.b.den) + 64'(op.b.num)) * 64'(op.a.den);
    den = 64'(op.a.den) * 64'(op.b.den);
    if (op.a.neg == op.b.neg) begin
      mag = p + q;
      neg = op.a.neg;
    end else if (p >= q) begin
      mag = p - q;
      neg = op.a.neg;
    end else begin
      mag = q - p;
      neg = op.b.neg;
    end
    if (mag == 64'd0) neg = 1'b0;
    if (den >= 64'(VALUE_LIMIT) || mag >= 64'(VALUE_LIMIT)) return TOO_LARGE_SUM;
    x = mag;
    y = den;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    n = mag / x;
    d = den / x;
    res.neg    = neg;
    res.whole  = FIELD_W'(n / d);
    res.num    = FIELD_W'(n % d);
    res.den    = FIELD_W'(d);
    res.status = STATUS_OK;
    return res;
  endfunction

  // mostly short stalls, a few long ones
  function automatic int unsigned stall_length();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 4);
    return $urandom_range(12, 150);
  endfunction

  function automatic int unsigned source_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return stall_length();
  endfunction

  // small denominators most of the time so that sums stay in range
  function automatic int unsigned pick_den();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 12);
    if (r < 90) return $urandom_range(1, 200);
    return $urandom_range(1, 1000);
  endfunction

  // proper fraction with random sign, whole part often tiny
  function automatic mixed_t small_mixed(input int unsigned den, input int unsigned max_whole);
    mixed_t m;
    m.neg = 1'($urandom);
    m.den = FIELD_W'(den);
    m.num = FIELD_W'($urandom_range(0, den - 1));
    if ($urandom_range(0, 1) == 1)
      m.whole = FIELD_W'($urandom_range(0, max_whole));
    else
      m.whole = FIELD_W'($urandom_range(0, (max_whole < 9) ? max_whole : 9));
    return m;
  endfunction

  // fields over the legal range, or over every bit pattern of the field
  function automatic mixed_t wide_mixed(input bit any_bits);
    mixed_t m;
    m.neg = 1'($urandom);
    if (any_bits) begin
      m.whole = FIELD_W'($urandom);
      m.num   = FIELD_W'($urandom);
      m.den   = FIELD_W'($urandom);
    end else begin
      m.whole = FIELD_W'($urandom_range(0, 999999));
      m.num   = FIELD_W'($urandom_range(0, 999999));
      m.den   = FIELD_W'($urandom_range(1, 999999));
    end
    return m;
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t pr;
    int unsigned   kind, ad, bd, k, max_whole;
    kind = $urandom_range(0, 99);
    ad = pick_den();
    bd = pick_den();
    max_whole = SAFE_MAG / (ad * bd);
    pr.a = small_mixed(ad, max_whole);
    pr.b = small_mixed(bd, max_whole);
    if (kind >= 60 && kind < 70) begin
      // exact cancellation, b sometimes written with a scaled fraction
      k = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 9) : 1;
      pr.b     = pr.a;
      pr.b.neg = ~pr.a.neg;
      pr.b.num = FIELD_W'(32'(pr.a.num) * k);
      pr.b.den = FIELD_W'(32'(pr.a.den) * k);
    end else if (kind >= 70 && kind < 80) begin
      pr.a = wide_mixed(1'b0);
      pr.b = wide_mixed(1'b0);
    end else if (kind >= 80 && kind < 90) begin
      pr.a = wide_mixed(1'b1);
      pr.b = wide_mixed(1'b1);
    end else if (kind >= 90 && kind < 95) begin
      k = $urandom_range(0, 2);
      if (k != 1) pr.a.den = '0;
      if (k != 0) pr.b.den = '0;
    end else if (kind >= 95) begin
      // improper numerators
      pr.a.num = FIELD_W'($urandom_range(0, 4 * ad));
      pr.b.num = FIELD_W'($urandom_range(0, 4 * bd));
    end
    return pr;
  endfunction

  function automatic string show_sum(input logic neg, input logic [FIELD_W-1:0] whole,
                                     input logic [FIELD_W-1:0] num,
                                     input logic [FIELD_W-1:0] den,
                                     input logic [STAT_W-1:0] status);
    return $sformatf("neg %0d whole %0d num %0d den %0d status %0d",
                     neg, whole, num, den, status);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // present one operand word after an optional gap, hold it until the block takes it,
  // then queue its sum; valid stays high across back-to-back words
  task automatic send_operands(input operand_pair_t ops, input mfa_result_t want,
                               input int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.a_negative <= ops.a.neg;
    in_ch.a_whole    <= ops.a.whole;
    in_ch.a_num      <= ops.a.num;
    in_ch.a_den      <= ops.a.den;
    in_ch.b_negative <= ops.b.neg;
    in_ch.b_whole    <= ops.b.whole;
    in_ch.b_num      <= ops.b.num;
    in_ch.b_den      <= ops.b.den;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_sums.push_back(want);
  endtask

  // result side back-pressure: random stalls unless in a steady stretch
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        hold = stall_length() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // every accepted result word against the oldest pending sum
  always @(posedge clk) begin : sum_checker
    mfa_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        flag_mismatch({"result word with no sum pending: ",
                       show_sum(out_ch.sum_negative, out_ch.sum_whole, out_ch.sum_num,
                                out_ch.sum_den, out_ch.status)});
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.sum_negative !== want.neg || out_ch.sum_whole !== want.whole ||
            out_ch.sum_num !== want.num || out_ch.sum_den !== want.den ||
            out_ch.status !== want.status) begin
          flag_mismatch({"expected ",
                         show_sum(want.neg, want.whole, want.num, want.den, want.status),
                         " got ",
                         show_sum(out_ch.sum_negative, out_ch.sum_whole, out_ch.sum_num,
                                  out_ch.sum_den, out_ch.status)});
        end
      end
    end
  end

  initial begin : stimulus
    operand_pair_t pair;
    mfa_result_t   want;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.a_negative = 1'b0;
    in_ch.a_whole    = '0;
    in_ch.a_num      = '0;
    in_ch.a_den      = '0;
    in_ch.b_negative = 1'b0;
    in_ch.b_whole    = '0;
    in_ch.b_num      = '0;
    in_ch.b_den      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table first
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].src == TYPED_IN)
        want = DIRECTED_ROWS[i].sum;
      else
        want = sum_fractions(DIRECTED_ROWS[i].ops);
      send_operands(DIRECTED_ROWS[i].ops, want, source_gap());
    end

    // random words, in blocks that are now and then free of idling
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 4) == 0);
      pair = random_pair();
      send_operands(pair, sum_fractions(pair), source_gap());
    end
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    // drain, then give a stray extra word time to show up
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
